// ===== rtl/core/metaball_marching_squares_defines.svh =====
// Assertion macros for the metaball contour block.
// Used by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef METABALL_MARCHING_SQUARES_DEFINES_SVH
`define METABALL_MARCHING_SQUARES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mms_pkg.sv =====
// Shared types, constants and helper functions of the metaball contour block.
// No dependencies; the divider and the top level refer to it by scoped names.
package mms_pkg;

    localparam int BALLS_DEF     = 4;
    localparam int GRID_STEP_DEF = 4;
    localparam int SCREEN_W_DEF  = 128;
    localparam int SCREEN_H_DEF  = 64;
    localparam int ROW_DEPTH     = 32;

    localparam int NUM_W = 36;
    localparam int DEN_W = 34;
    localparam int Q_W   = 16;

    localparam logic [15:0]      THR_RESET = 16'd1843;
    localparam logic [DEN_W-1:0] DIST_BIAS = 34'd6554;
    localparam logic [15:0]      FIELD_MAX = 16'hFFFF;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_LEFT   = 2'd3;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic           ovf;
        logic [Q_W-1:0] q;
    } t_div_rsp;

    // Segment count, then start and end edge of the first and second segment.
    typedef struct packed {
        logic [1:0] n;
        logic [1:0] a0;
        logic [1:0] b0;
        logic [1:0] a1;
        logic [1:0] b1;
    } t_seg_entry;

    function automatic t_seg_entry seg_lookup(input logic [3:0] cs);
        t_seg_entry e;
        e = '0;
        unique case (cs)
            4'd1, 4'd14: e = '{2'd1, EDGE_LEFT, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
            4'd2, 4'd13: e = '{2'd1, EDGE_RIGHT, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
            4'd3, 4'd12: e = '{2'd1, EDGE_LEFT, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
            4'd4, 4'd11: e = '{2'd1, EDGE_TOP, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
            4'd5:        e = '{2'd2, EDGE_LEFT, EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM};
            4'd6, 4'd9:  e = '{2'd1, EDGE_TOP, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
            4'd7:        e = '{2'd1, EDGE_LEFT, EDGE_TOP, EDGE_TOP, EDGE_TOP};
            4'd8:        e = '{2'd1, EDGE_TOP, EDGE_LEFT, EDGE_TOP, EDGE_TOP};
            4'd10:       e = '{2'd2, EDGE_TOP, EDGE_LEFT, EDGE_RIGHT, EDGE_BOTTOM};
            default:     e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] sat8(input logic signed [18:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 19'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/mms_if.sv =====
// Valid/ready channel interfaces for sample/load items and contour segments.
// Depends on nothing.
interface mms_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [1:0]  ball_index;
    logic [14:0] ball_x;
    logic [13:0] ball_y;
    logic [11:0] ball_radius;
    logic [4:0]  grid_x;
    logic [3:0]  grid_y;

    modport source (output valid, op, ball_index, ball_x, ball_y, ball_radius,
                    grid_x, grid_y, input ready);
    modport sink (input valid, op, ball_index, ball_x, ball_y, ball_radius,
                  grid_x, grid_y, output ready);
endinterface

interface mms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] seg_x0;
    logic [7:0] seg_y0;
    logic [7:0] seg_x1;
    logic [7:0] seg_y1;
    logic       last;

    modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, last, input ready);
    modport sink (input valid, seg_x0, seg_y0, seg_x1, seg_y1, last, output ready);
endinterface

// ===== rtl/core/mms_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on mms_pkg; flags a quotient that does not fit in 16 bits.
module mms_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mms_pkg::t_div_req i_req,
    output mms_pkg::t_div_rsp o_rsp
);
    localparam int NW = mms_pkg::NUM_W;
    localparam int DW = mms_pkg::DEN_W;
    localparam int QW = mms_pkg::Q_W;
    localparam int SW = DW + QW - 1;
    localparam int CW = $clog2(QW);

    logic                    r_busy;
    logic                    r_done;
    logic [CW-1:0]           r_cnt;
    logic [NW-1:0]           r_rem;
    logic [SW-1:0]           r_d;
    logic [QW-1:0]           r_q;
    logic                    r_ovf;
    logic                    w_ge;

    assign w_ge = {{(SW-NW){1'b0}}, r_rem} >= r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_d   <= {i_req.den, {(QW-1){1'b0}}};
            r_q   <= '0;
            r_ovf <= {{(DW+QW-NW){1'b0}}, i_req.num} >= {i_req.den, {QW{1'b0}}};
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_d[NW-1:0];
            end
            r_q <= {r_q[QW-2:0], w_ge};
            r_d <= r_d >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.q    = r_q;
endmodule

// ===== rtl/core/metaball_marching_squares.sv =====
// Metaball field sampler with marching-squares contour output.
// A load item is taken in S_IDLE. A sample runs, for each ball, the set-up states S_DIST,
// S_SQX, S_SQY and S_SQR and then a division in the shared divider; a cell with segments
// adds a division for each of the four cell edges and one transfer per segment; no overlap.
// Receiver stalls lengthen the segment phase. Reset is synchronous, active low: ball
// store and upper-left and left corner fields clear, and the threshold returns to its default of 0.45.
`include "metaball_marching_squares_defines.svh"

module metaball_marching_squares #(
    parameter int BALLS     = mms_pkg::BALLS_DEF,
    parameter int GRID_STEP = mms_pkg::GRID_STEP_DEF,
    parameter int SCREEN_W  = mms_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H  = mms_pkg::SCREEN_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    mms_in_if.sink      i_in,
    mms_out_if.source   o_out
);
    localparam int BW   = (BALLS > 1) ? $clog2(BALLS) : 1;
    localparam int HALF = GRID_STEP / 2;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DIST = 10'b0000000010,
        S_SQX  = 10'b0000000100,
        S_SQY  = 10'b0000001000,
        S_SQR  = 10'b0000010000,
        S_BDIV = 10'b0000100000,
        S_LINE = 10'b0001000000,
        S_EMUL = 10'b0010000000,
        S_EDIV = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [14:0] r_ball_x [BALLS];
    logic [13:0] r_ball_y [BALLS];
    logic [11:0] r_ball_r [BALLS];
    logic [15:0] r_row [mms_pkg::ROW_DEPTH];

    logic [15:0]  r_thr;
    logic [15:0]  r_ul;
    logic [15:0]  r_left;
    logic [15:0]  r_tr;
    logic [15:0]  r_field;
    logic [4:0]   r_gx;
    logic [3:0]   r_gy;
    logic [7:0]   r_px;
    logic [7:0]   r_py;
    logic [BW-1:0] r_b;
    logic [15:0]  r_ax;
    logic [15:0]  r_ay;
    logic [mms_pkg::DEN_W-1:0] r_dist;
    logic [15:0]  r_c [4];
    mms_pkg::t_seg_entry r_seg;
    logic [1:0]   r_e;
    logic         r_eneg;
    logic         r_ezero;
    logic [7:0]   r_ev [4];
    logic         r_k;

    mms_pkg::t_div_req w_req;
    mms_pkg::t_div_rsp w_rsp;

    logic         w_in_xfer;
    logic         w_out_xfer;
    logic [9:0]   w_px_raw;
    logic [9:0]   w_py_raw;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [15:0]  w_ma;
    logic [15:0]  w_mb;
    logic [31:0]  w_prod;
    logic [16:0]  w_sum;
    logic [3:0]   w_cs;
    mms_pkg::t_seg_entry w_seg;
    logic [15:0]  w_f1;
    logic [15:0]  w_f2;
    logic signed [16:0] w_enum;
    logic signed [16:0] w_eden;
    logic [15:0]  w_anum;
    logic [15:0]  w_aden;
    logic [9:0]   w_cx;
    logic [9:0]   w_cy;
    logic [9:0]   w_base;
    logic signed [18:0] w_off;
    logic [7:0]   w_fx [4];
    logic [7:0]   w_fy [4];
    logic [1:0]   w_ea;
    logic [1:0]   w_eb;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;

    // Sample pixel, clamped to the screen.
    assign w_px_raw = 10'(i_in.grid_x) * 10'(GRID_STEP) + 10'(HALF);
    assign w_py_raw = 10'(i_in.grid_y) * 10'(GRID_STEP) + 10'(HALF);

    assign w_dx = $signed({1'b0, r_px, 8'b0}) - $signed({2'b0, r_ball_x[r_b]});
    assign w_dy = $signed({1'b0, r_py, 8'b0}) - $signed({3'b0, r_ball_y[r_b]});

    // Edge e runs from corner e to corner e+1: top, right, bottom, left.
    assign w_f1   = r_c[r_e];
    assign w_f2   = r_c[r_e + 2'd1];
    assign w_enum = $signed({1'b0, r_thr}) - $signed({1'b0, w_f1});
    assign w_eden = $signed({1'b0, w_f2}) - $signed({1'b0, w_f1});
    assign w_anum = w_enum[16] ? 16'(-w_enum) : w_enum[15:0];
    assign w_aden = w_eden[16] ? 16'(-w_eden) : w_eden[15:0];

    // One shared multiplier serves the squares and the edge scaling.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SQX: begin
                w_ma = r_ax;
                w_mb = r_ax;
            end
            S_SQY: begin
                w_ma = r_ay;
                w_mb = r_ay;
            end
            S_SQR: begin
                w_ma = {4'b0, r_ball_r[r_b]};
                w_mb = {4'b0, r_ball_r[r_b]};
            end
            S_EMUL: begin
                w_ma = 16'(GRID_STEP);
                w_mb = w_anum;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = '0;
        w_req.den   = '0;
        if (r_state == S_SQR) begin
            w_req.start = 1'b1;
            w_req.num   = {w_prod[23:0], 12'b0};
            w_req.den   = r_dist;
        end else if (r_state == S_EMUL) begin
            w_req.start = 1'b1;
            w_req.num   = mms_pkg::NUM_W'(w_prod);
            w_req.den   = mms_pkg::DEN_W'(w_aden);
        end
    end

    mms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_sum = 17'(r_field) + 17'(w_rsp.q);

    assign w_cs  = {r_ul > r_thr, r_tr > r_thr, r_field > r_thr, r_left > r_thr};
    assign w_seg = mms_pkg::seg_lookup(w_cs);

    assign w_cx = 10'(r_gx - 5'd1) * 10'(GRID_STEP) + 10'(HALF);
    assign w_cy = 10'({1'b0, r_gy} - 5'd1) * 10'(GRID_STEP) + 10'(HALF);

    always_comb begin
        unique case (r_e)
            mms_pkg::EDGE_TOP:    w_base = w_cx;
            mms_pkg::EDGE_RIGHT:  w_base = w_cy;
            mms_pkg::EDGE_BOTTOM: w_base = w_cx + 10'(GRID_STEP);
            default:              w_base = w_cy + 10'(GRID_STEP);
        endcase
    end

    // Offset takes the quotient's sign, flipped on bottom/left; a flat edge gives its start.
    always_comb begin
        if (r_ezero) begin
            w_off = '0;
        end else if (r_eneg) begin
            w_off = -$signed({3'b0, w_rsp.q});
        end else begin
            w_off = $signed({3'b0, w_rsp.q});
        end
    end

    // Fixed coordinate of each edge point; the other one is interpolated.
    always_comb begin
        w_fx[0] = r_ev[0];
        w_fy[0] = mms_pkg::sat8(19'({9'b0, w_cy}));
        w_fx[1] = mms_pkg::sat8(19'({9'b0, w_cx}) + 19'(GRID_STEP));
        w_fy[1] = r_ev[1];
        w_fx[2] = r_ev[2];
        w_fy[2] = mms_pkg::sat8(19'({9'b0, w_cy}) + 19'(GRID_STEP));
        w_fx[3] = mms_pkg::sat8(19'({9'b0, w_cx}));
        w_fy[3] = r_ev[3];
    end

    assign w_ea = r_k ? r_seg.a1 : r_seg.a0;
    assign w_eb = r_k ? r_seg.b1 : r_seg.b0;

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = (r_state == S_OUT);
    assign o_out.seg_x0 = w_fx[w_ea];
    assign o_out.seg_y0 = w_fy[w_ea];
    assign o_out.seg_x1 = w_fx[w_eb];
    assign o_out.seg_y1 = w_fy[w_eb];
    assign o_out.last   = r_k || (r_seg.n == 2'd1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && i_in.op == mms_pkg::OP_SAMPLE) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_SQR;
            S_SQR:  n_state = S_BDIV;
            S_BDIV: begin
                if (w_rsp.done) begin
                    n_state = (r_b == BW'(BALLS - 1)) ? S_LINE : S_DIST;
                end
            end
            S_LINE: begin
                if (r_gx == 5'd0 || r_gy == 4'd0 || w_seg.n == 2'd0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMUL;
                end
            end
            S_EMUL: n_state = S_EDIV;
            S_EDIV: begin
                if (w_rsp.done) begin
                    n_state = (r_e == mms_pkg::EDGE_LEFT) ? S_OUT : S_EMUL;
                end
            end
            S_OUT: begin
                if (w_out_xfer && o_out.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= mms_pkg::THR_RESET;
            r_ul    <= '0;
            r_left  <= '0;
            for (int j = 0; j < BALLS; j++) begin
                r_ball_x[j] <= '0;
                r_ball_y[j] <= '0;
                r_ball_r[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_in_xfer && i_in.op == mms_pkg::OP_LOAD) begin
                for (int j = 0; j < BALLS; j++) begin
                    if (32'(i_in.ball_index) == j) begin
                        r_ball_x[j] <= i_in.ball_x;
                        r_ball_y[j] <= i_in.ball_y;
                        r_ball_r[j] <= i_in.ball_radius;
                    end
                end
            end
            if (r_state == S_LINE) begin
                r_ul   <= r_tr;
                r_left <= r_field;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_gx    <= i_in.grid_x;
                r_gy    <= i_in.grid_y;
                r_px    <= (w_px_raw > 10'(SCREEN_W - 1)) ? 8'(SCREEN_W - 1) : w_px_raw[7:0];
                r_py    <= (w_py_raw > 10'(SCREEN_H - 1)) ? 8'(SCREEN_H - 1) : w_py_raw[7:0];
                r_tr    <= r_row[i_in.grid_x];
                r_b     <= '0;
                r_field <= '0;
            end
            S_DIST: begin
                r_ax <= w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
                r_ay <= w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
            end
            S_SQX: r_dist <= mms_pkg::DEN_W'(w_prod);
            S_SQY: r_dist <= r_dist + mms_pkg::DEN_W'(w_prod) + mms_pkg::DIST_BIAS;
            S_SQR: r_b <= r_b;
            S_BDIV: begin
                if (w_rsp.done) begin
                    r_field <= (w_rsp.ovf || w_sum[16]) ? mms_pkg::FIELD_MAX : w_sum[15:0];
                    r_b     <= r_b + 1'b1;
                end
            end
            S_LINE: begin
                r_row[r_gx] <= r_field;
                r_c[0]      <= r_ul;
                r_c[1]      <= r_tr;
                r_c[2]      <= r_field;
                r_c[3]      <= r_left;
                r_seg       <= w_seg;
                r_e         <= mms_pkg::EDGE_TOP;
                r_k         <= 1'b0;
            end
            S_EMUL: begin
                r_eneg  <= w_enum[16] ^ w_eden[16] ^ r_e[1];
                r_ezero <= (w_eden == 17'sd0);
            end
            S_EDIV: begin
                if (w_rsp.done) begin
                    r_ev[r_e] <= mms_pkg::sat8($signed({9'b0, w_base}) + w_off);
                    r_e       <= r_e + 2'd1;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    r_k <= 1'b1;
                end
            end
            default: r_k <= r_k;
        endcase
    end

    `MMS_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(r_state), "state register not one-hot")
    `MMS_ASSERT_IMP(a_no_overlap, o_out.valid, !i_in.ready, "input taken while a segment waits")
    `MMS_ASSERT_NXT(a_last_idle, w_out_xfer && o_out.last, r_state == S_IDLE,
                    "block not idle after the last segment transfer")
    `MMS_ASSERT_IMP(a_div_start, w_req.start, r_state == S_SQR || r_state == S_EMUL,
                    "divider started outside a start state")

endmodule
